[hw/rtl/dtt_pkg.sv]
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants of the detection track table.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned FrameW = 16;
  localparam int unsigned HitsW  = 8;

  // outcome codes
  localparam logic [2:0] OutHitConf  = 3'd0;
  localparam logic [2:0] OutHitTent  = 3'd1;
  localparam logic [2:0] OutNewTent  = 3'd2;
  localparam logic [2:0] OutDropped  = 3'd3;
  localparam logic [2:0] OutFrameEnd = 3'd4;

  // register indexes
  localparam logic [1:0] RegRecent = 2'd0;
  localparam logic [1:0] RegExpire = 2'd1;
  localparam logic [1:0] RegHits   = 2'd2;

  // q8 limits
  localparam logic [8:0] TightLo = 9'd230;
  localparam logic [8:0] TightHi = 9'd284;
  localparam logic [8:0] TightMv = 9'd192;
  localparam logic [8:0] LooseLo = 9'd179;
  localparam logic [8:0] LooseHi = 9'd366;
  localparam logic [8:0] LooseMv = 9'd384;

  // one stored entry
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
    logic [FrameW-1:0] seen;
    logic [HitsW-1:0]  hits;
  } entry_t;

endpackage

[hw/rtl/detection_track_table_unit.sv]
// ----------------------------------------------------------------------------
// detection_track_table_unit
// Two-table box tracker: detection matching, end-of-frame promote and purge.
// ----------------------------------------------------------------------------
// Each table sits in its own single-port-read memory and one sequencer walks
// it an entry at a time: a read, a registered fit test, then a decision. A
// detection searches the valid entries, confirmed first, then tentative,
// until one fits; each of the two tables holds up to 16. End of frame walks
// the tentative table once, promoting and purging it in the same pass, and
// then walks the confirmed table once to purge it. The result is held in an
// output register; a new item is taken once it has gone.
module detection_track_table_unit import dtt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [11:0] det_x_i,
  input  logic [11:0] det_y_i,
  input  logic [11:0] det_w_i,
  input  logic [11:0] det_h_i,
  input  logic [15:0] frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  outcome_o,
  output logic [3:0]  slot_o,
  output logic [4:0]  confirmed_count_o,
  output logic [4:0]  tentative_count_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    StIdle, StSRead, StSWait, StSTest, StSWrite,
    StPRead, StPWait, StPMove,
    StCRead, StCWait, StCMove, StDone
  } state_e;

  state_e        state_q;
  logic          tab_q;      // 0 confirmed, 1 tentative
  logic [CW-1:0] idx_q, k_q;
  logic [CW-1:0] conf_used_q, tent_used_q;
  logic [11:0]   x_q, y_q, w_q, h_q;
  logic [15:0]   frame_q;
  logic [7:0]    recent_q, hreq_q;
  logic [9:0]    expire_q;
  logic          out_valid_q, out_valid_d;
  logic [2:0]    outcome_q;
  logic [3:0]    slot_q;

  logic          c_we, t_we;
  logic [AW-1:0] c_wa, t_wa, c_ra, t_ra;
  entry_t        c_wd, t_wd, c_rd, t_rd, rd, upd;
  logic          fit;
  logic [15:0]   age;
  logic          promote, keep;

  dtt_mem #(.Depth(TABLE_DEPTH)) u_conf (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c_ra), .rdata_o(c_rd)
  );
  dtt_mem #(.Depth(TABLE_DEPTH)) u_tent (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd)
  );

  assign rd = tab_q ? t_rd : c_rd;

  dtt_fit u_fit (
    .clk_i, .ent_i(rd), .det_x_i(x_q), .det_y_i(y_q), .det_w_i(w_q),
    .det_h_i(h_q), .frame_i(frame_q), .recent_window_i(recent_q), .fit_o(fit)
  );

  assign age     = frame_q - rd.seen;
  assign promote = (rd.hits > hreq_q) && (conf_used_q < Full);
  assign keep    = age <= 16'(expire_q);

  // hit update of the entry just read
  always_comb begin
    upd      = '{x: x_q, y: y_q, w: w_q, h: h_q, seen: frame_q, hits: 8'd1};
    if (state_q == StSWrite && outcome_q != OutNewTent) begin
      upd.hits = (rd.hits == 8'hFF) ? 8'hFF : rd.hits + 8'd1;
    end
  end

  // memory port steering
  always_comb begin
    c_we = 1'b0; t_we = 1'b0;
    c_wa = k_q[AW-1:0]; t_wa = k_q[AW-1:0];
    c_wd = rd; t_wd = rd;
    c_ra = idx_q[AW-1:0]; t_ra = idx_q[AW-1:0];
    unique case (state_q)
      StSWrite: begin
        c_wa = idx_q[AW-1:0]; t_wa = idx_q[AW-1:0];
        c_wd = upd; t_wd = upd;
        c_we = ~tab_q; t_we = tab_q;
      end
      StIdle, StSRead, StSWait, StPRead, StPWait, StCRead, StCWait, StDone: begin
        if (state_q == StSTest) c_we = 1'b0;
      end
      StSTest: begin
        // append a new tentative entry on a miss at the last one
        t_wa = tent_used_q[AW-1:0];
        t_wd = upd;
        t_we = !fit && (idx_q + CW'(1) >= (tab_q ? tent_used_q : conf_used_q)) &&
               (tab_q || (tent_used_q == '0)) && (tent_used_q < Full);
      end
      StPMove: begin
        if (promote) begin
          c_we = 1'b1; c_wa = conf_used_q[AW-1:0];
        end else if (keep) begin
          t_we = 1'b1;
        end
      end
      StCMove: begin
        c_we = keep;
      end
      default: ;
    endcase
  end

  // result valid: set when a result is ready, cleared once taken
  assign out_valid_d = (state_q == StDone) ? 1'b1 : (out_valid_q && out_stall_i);

  // sequencer, counts, configuration and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tab_q       <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      conf_used_q <= '0;
      tent_used_q <= '0;
      recent_q    <= 8'd5;
      expire_q    <= 10'd10;
      hreq_q      <= 8'd3;
      out_valid_q <= 1'b0;
      outcome_q   <= OutHitConf;
      slot_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegRecent: recent_q <= cfg_data_i[7:0];
          RegExpire: expire_q <= cfg_data_i;
          RegHits:   hreq_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      out_valid_q <= out_valid_d;
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && !in_stall_o) begin
            x_q <= det_x_i; y_q <= det_y_i;
            w_q <= det_w_i; h_q <= det_h_i; frame_q <= frame_i;
            idx_q <= '0; k_q <= '0;
            if (mode_i) begin
              tab_q <= (tent_used_q != '0);
              state_q <= (tent_used_q != '0) ? StPRead : StCRead;
            end else if (conf_used_q != '0) begin
              tab_q <= 1'b0; state_q <= StSRead;
            end else if (tent_used_q != '0) begin
              tab_q <= 1'b1; state_q <= StSRead;
            end else begin
              outcome_q <= OutNewTent; slot_q <= '0;
              tent_used_q <= CW'(1); tab_q <= 1'b1;
              state_q <= StSWrite;
            end
          end
        end
        StSRead: state_q <= StSWait;
        StSWait: state_q <= StSTest;
        StSTest: begin
          if (fit) begin
            outcome_q <= tab_q ? OutHitTent : OutHitConf;
            slot_q    <= 4'(idx_q);
            state_q   <= StSWrite;
          end else if (idx_q + CW'(1) < (tab_q ? tent_used_q : conf_used_q)) begin
            idx_q <= idx_q + CW'(1); state_q <= StSRead;
          end else if (!tab_q && tent_used_q != '0) begin
            tab_q <= 1'b1; idx_q <= '0; state_q <= StSRead;
          end else if (tent_used_q < Full) begin
            outcome_q <= OutNewTent; slot_q <= 4'(tent_used_q);
            tent_used_q <= tent_used_q + CW'(1);
            state_q <= StDone;
          end else begin
            outcome_q <= OutDropped; slot_q <= '0; state_q <= StDone;
          end
        end
        StSWrite: begin
          // also reached for the first append into empty tables
          state_q <= StDone;
        end
        StPRead: state_q <= StPWait;
        StPWait: state_q <= StPMove;
        StPMove: begin
          if (promote) begin
            conf_used_q <= conf_used_q + CW'(1);
          end
          if (idx_q + CW'(1) < tent_used_q) begin
            if (!promote && keep) k_q <= k_q + CW'(1);
            idx_q <= idx_q + CW'(1); state_q <= StPRead;
          end else begin
            tent_used_q <= (!promote && keep) ? k_q + CW'(1) : k_q;
            tab_q <= 1'b0; idx_q <= '0; k_q <= '0;
            state_q <= StCRead;
          end
        end
        StCRead: begin
          if (idx_q >= conf_used_q) begin
            conf_used_q <= k_q; outcome_q <= OutFrameEnd; slot_q <= '0;
            state_q <= StDone;
          end else begin
            state_q <= StCWait;
          end
        end
        StCWait: state_q <= StCMove;
        StCMove: begin
          if (keep) k_q <= k_q + CW'(1);
          idx_q <= idx_q + CW'(1); state_q <= StCRead;
        end
        StDone: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // the first append into empty tables writes through the hit path
  // (hits is forced to one there since rd is unused for a new entry)

  assign in_stall_o        = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign out_valid_o       = out_valid_q;
  assign outcome_o         = outcome_q;
  assign slot_o            = slot_q;
  assign confirmed_count_o = 5'(conf_used_q);
  assign tentative_count_o = 5'(tent_used_q);

endmodule

[hw/rtl/dtt_fit.sv]
// ----------------------------------------------------------------------------
// dtt_fit
// Registered match test of a stored entry against the detection box.
// ----------------------------------------------------------------------------
module dtt_fit import dtt_pkg::*; (
  input  logic              clk_i,
  input  entry_t            ent_i,
  input  logic [CoordW-1:0] det_x_i,
  input  logic [CoordW-1:0] det_y_i,
  input  logic [CoordW-1:0] det_w_i,
  input  logic [CoordW-1:0] det_h_i,
  input  logic [FrameW-1:0] frame_i,
  input  logic [7:0]        recent_window_i,
  output logic              fit_o
);

  logic [FrameW-1:0] age;
  logic              recent;
  logic [8:0]        lo, hi, mv;
  logic [20:0]       dw, dh, lw, hw, lh, hh, dx, dy, mx, my;
  logic [CoordW-1:0] ax, ay;

  // limits by age
  assign age    = frame_i - ent_i.seen;
  assign recent = age <= FrameW'(recent_window_i);
  assign lo = recent ? TightLo : LooseLo;
  assign hi = recent ? TightHi : LooseHi;
  assign mv = recent ? TightMv : LooseMv;

  // cross-multiplied tests
  assign ax = (det_x_i > ent_i.x) ? det_x_i - ent_i.x : ent_i.x - det_x_i;
  assign ay = (det_y_i > ent_i.y) ? det_y_i - ent_i.y : ent_i.y - det_y_i;
  assign dw = {1'b0, det_w_i, 8'd0};
  assign dh = {1'b0, det_h_i, 8'd0};
  assign dx = {1'b0, ax, 8'd0};
  assign dy = {1'b0, ay, 8'd0};
  assign lw = lo * ent_i.w;
  assign hw = hi * ent_i.w;
  assign lh = lo * ent_i.h;
  assign hh = hi * ent_i.h;
  assign mx = mv * ent_i.w;
  assign my = mv * ent_i.h;

  always_ff @(posedge clk_i) begin
    fit_o <= (dw >= lw) && (dw <= hw) && (dh >= lh) && (dh <= hh)
             && (dx <= mx) && (dy <= my);
  end

endmodule

[hw/rtl/dtt_mem.sv]
// ----------------------------------------------------------------------------
// dtt_mem
// Entry store of one table, one write and one registered read port.
// ----------------------------------------------------------------------------
module dtt_mem import dtt_pkg::*; #(
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  entry_t mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[test/detection_track_table_unit_tb.sv]
// ----------------------------------------------------------------------------
// detection_track_table_unit_tb
// Self-checking bench for the two-table box tracker. Detections follow
// jittered object tracks over many frames, mixed with fresh and noisy boxes.
// The bench predicts each result from its own copy of both tables and checks
// every result item field by field. Both handshakes idle at random, and the
// run goes through several register settings.
// ----------------------------------------------------------------------------
module detection_track_table_unit_tb;
  import dtt_pkg::*;

  localparam int Depth    = 16;
  localparam int MaxCycle = 3000000;
  localparam int Drain    = 150;

  typedef struct {
    logic        mode;
    logic [11:0] x, y, w, h;
    logic [15:0] frame;
  } det_item_t;

  typedef struct {
    logic [2:0] outcome;
    logic [3:0] slot;
    logic [4:0] n_conf, n_tent;
  } track_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = RegRecent;
  logic [9:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [11:0] det_x_i = '0, det_y_i = '0, det_w_i = 12'd1, det_h_i = 12'd1;
  logic [15:0] frame_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  outcome_o;
  logic [3:0]  slot_o;
  logic [4:0]  confirmed_count_o, tentative_count_o;

  detection_track_table_unit dut (.*);

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // bench state
  det_item_t  pending_q[$];
  track_res_t track_exp_q[$];
  int         n_errors = 0;
  int         n_checked = 0;
  int         n_outcome[5] = '{default: 0};
  int         cycle_cnt = 0;

  // tracker copy used for prediction
  entry_t      conf_tab[Depth];
  entry_t      tent_tab[Depth];
  int          conf_n = 0, tent_n = 0;
  logic [7:0]  recent_win = 8'd5;
  logic [9:0]  expire_lim = 10'd10;
  logic [7:0]  hits_need = 8'd3;

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MaxCycle) begin
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [15:0] age_of(entry_t e, logic [15:0] frame);
    return frame - e.seen;
  endfunction

  function automatic bit box_fits(entry_t e, det_item_t it);
    int unsigned lo, hi, mv, dx, dy;
    bit recent;
    recent = age_of(e, it.frame) <= recent_win;
    lo = recent ? TightLo : LooseLo;
    hi = recent ? TightHi : LooseHi;
    mv = recent ? TightMv : LooseMv;
    dx = (it.x > e.x) ? it.x - e.x : e.x - it.x;
    dy = (it.y > e.y) ? it.y - e.y : e.y - it.y;
    if (256 * it.w < lo * e.w || 256 * it.w > hi * e.w) return 0;
    if (256 * it.h < lo * e.h || 256 * it.h > hi * e.h) return 0;
    if (dx * 256 > mv * e.w || dy * 256 > mv * e.h) return 0;
    return 1;
  endfunction

  function automatic entry_t box_entry(det_item_t it, logic [7:0] hits);
    entry_t e;
    e.x = it.x; e.y = it.y; e.w = it.w; e.h = it.h;
    e.seen = it.frame;
    e.hits = hits;
    return e;
  endfunction

  // expected result of one item, updating the table copy
  function automatic track_res_t track_predict(det_item_t it);
    track_res_t r;
    int k, hit;
    r.slot = '0;
    hit = -1;
    if (it.mode) begin
      // promote in order, then purge both tables keeping the order
      k = 0;
      for (int i = 0; i < tent_n; i++) begin
        if (tent_tab[i].hits > hits_need && conf_n < Depth) begin
          conf_tab[conf_n] = tent_tab[i];
          conf_n++;
        end else begin
          tent_tab[k] = tent_tab[i];
          k++;
        end
      end
      tent_n = k;
      k = 0;
      for (int i = 0; i < conf_n; i++)
        if (age_of(conf_tab[i], it.frame) <= expire_lim) begin
          conf_tab[k] = conf_tab[i];
          k++;
        end
      conf_n = k;
      k = 0;
      for (int i = 0; i < tent_n; i++)
        if (age_of(tent_tab[i], it.frame) <= expire_lim) begin
          tent_tab[k] = tent_tab[i];
          k++;
        end
      tent_n = k;
      r.outcome = OutFrameEnd;
    end else begin
      for (int i = 0; i < conf_n && hit < 0; i++)
        if (box_fits(conf_tab[i], it)) hit = i;
      if (hit >= 0) begin
        conf_tab[hit] = box_entry(it, (conf_tab[hit].hits == 8'hff) ? 8'hff :
                                      conf_tab[hit].hits + 8'd1);
        r.outcome = OutHitConf;
        r.slot = hit;
      end else begin
        for (int i = 0; i < tent_n && hit < 0; i++)
          if (box_fits(tent_tab[i], it)) hit = i;
        if (hit >= 0) begin
          tent_tab[hit] = box_entry(it, (tent_tab[hit].hits == 8'hff) ? 8'hff :
                                        tent_tab[hit].hits + 8'd1);
          r.outcome = OutHitTent;
          r.slot = hit;
        end else if (tent_n < Depth) begin
          tent_tab[tent_n] = box_entry(it, 8'd1);
          r.slot = tent_n;
          tent_n++;
          r.outcome = OutNewTent;
        end else begin
          r.outcome = OutDropped;
        end
      end
    end
    r.n_conf = conf_n;
    r.n_tent = tent_n;
    return r;
  endfunction

  // sender: bursts of items with random gaps, prediction on acceptance
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    det_item_t it;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        it.mode = mode_i; it.x = det_x_i; it.y = det_y_i;
        it.w = det_w_i; it.h = det_h_i; it.frame = frame_i;
        track_exp_q.push_back(track_predict(it));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          it = pending_q.pop_front();
          mode_i <= it.mode; det_x_i <= it.x; det_y_i <= it.y;
          det_w_i <= it.w; det_h_i <= it.h; frame_i <= it.frame;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern of its own plus a periodic long hold-off
  int rx_cyc = 0;
  int hold_left = 0;
  int rx_pat = 0;
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 97 == 0) rx_pat <= $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_cyc % 20000 == 9000) begin
      hold_left <= 800;
      out_stall_i <= 1'b1;
    end else begin
      case (rx_pat)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= ($urandom_range(0, 9) < 8);
        default: out_stall_i <= ((rx_cyc / 5) % 2 == 1);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    track_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (track_exp_q.size() == 0) begin
        $display("%0t: unexpected result outcome=%0d slot=%0d", $time, outcome_o, slot_o);
        n_errors++;
      end else begin
        e = track_exp_q.pop_front();
        n_checked++;
        if (e.outcome <= OutFrameEnd) n_outcome[e.outcome]++;
        if (outcome_o !== e.outcome) begin
          $display("%0t: outcome expected %0d got %0d", $time, e.outcome, outcome_o);
          n_errors++;
        end
        if (slot_o !== e.slot) begin
          $display("%0t: slot expected %0d got %0d", $time, e.slot, slot_o);
          n_errors++;
        end
        if (confirmed_count_o !== e.n_conf) begin
          $display("%0t: confirmed count expected %0d got %0d", $time, e.n_conf,
                   confirmed_count_o);
          n_errors++;
        end
        if (tentative_count_o !== e.n_tent) begin
          $display("%0t: tentative count expected %0d got %0d", $time, e.n_tent,
                   tentative_count_o);
          n_errors++;
        end
      end
    end
  end

  // stimulus helpers
  function automatic det_item_t mk_det(int x, int y, int w, int h, int f);
    det_item_t it;
    it.mode = 1'b0; it.x = x; it.y = y; it.w = w; it.h = h; it.frame = f;
    return it;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic push_eof(int f);
    det_item_t it;
    it = mk_det(0, 0, 1, 1, f);
    it.mode = 1'b1;
    pending_q.push_back(it);
  endtask

  // sampled between edges so that all driven values have settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || track_exp_q.size() != 0);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegRecent: recent_win = val[7:0];
      RegExpire: expire_lim = val;
      default:   hits_need = val[7:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  int trk_x[12], trk_y[12], trk_w[12], trk_h[12];

  // one phase of tracked objects over a run of frames
  task automatic run_phase(int rw, int ef, int hr, int n_frames, int f0);
    int f, t, n, w, h;
    write_reg(RegRecent, 10'(rw));
    write_reg(RegExpire, 10'(ef));
    write_reg(RegHits, 10'(hr));
    for (int i = 0; i < 12; i++) begin
      trk_w[i] = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4095)
                                             : $urandom_range(4, 300);
      trk_h[i] = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4095)
                                             : $urandom_range(4, 300);
      trk_x[i] = $urandom_range(0, 4095);
      trk_y[i] = $urandom_range(0, 4095);
    end
    f = f0;
    for (int fr = 0; fr < n_frames; fr++) begin
      n = $urandom_range(1, 9);
      for (int d = 0; d < n; d++) begin
        if ($urandom_range(0, 9) < 8) begin
          // jittered detection of a known object
          t = $urandom_range(0, 11);
          w = clip(trk_w[t] + $signed($urandom_range(0, 2 * (trk_w[t] / 12 + 1)))
                   - (trk_w[t] / 12 + 1), 1, 4095);
          h = clip(trk_h[t] + $signed($urandom_range(0, 2 * (trk_h[t] / 12 + 1)))
                   - (trk_h[t] / 12 + 1), 1, 4095);
          trk_x[t] = clip(trk_x[t] + $signed($urandom_range(0, trk_w[t] / 2))
                          - trk_w[t] / 4, 0, 4095);
          trk_y[t] = clip(trk_y[t] + $signed($urandom_range(0, trk_h[t] / 2))
                          - trk_h[t] / 4, 0, 4095);
          trk_w[t] = w;
          trk_h[t] = h;
          pending_q.push_back(mk_det(trk_x[t], trk_y[t], w, h, f));
        end else begin
          // noise box
          pending_q.push_back(mk_det($urandom_range(0, 4095), $urandom_range(0, 4095),
                                     $urandom_range(1, 4095), $urandom_range(1, 4095), f));
        end
      end
      push_eof(f);
      f = (f + (($urandom_range(0, 7) == 0) ? $urandom_range(2, 30) : 1)) & 16'hffff;
    end
    wait_idle();
  endtask

  // main sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, a full tentative table and frame wrap purge
    pending_q.push_back(mk_det(0, 0, 1, 1, 0));
    pending_q.push_back(mk_det(4095, 4095, 4095, 4095, 65535));
    pending_q.push_back(mk_det(4095, 4095, 4000, 4095, 65535));
    for (int i = 0; i < 16; i++)
      pending_q.push_back(mk_det(i * 250 + 20, 2048, 10, 10, 0));
    push_eof(0);
    pending_q.push_back(mk_det(1, 1, 1, 1, 3));
    push_eof(65535);
    wait_idle();

    // settings including the extremes of the recent and hits registers, and expire limits of 1 and 1023
    run_phase(5, 10, 3, 22, $urandom_range(0, 65535));
    run_phase(0, 1, 0, 22, 65520);
    run_phase(255, 1023, 0, 25, $urandom_range(0, 65535));
    run_phase(255, 1023, 255, 20, $urandom_range(0, 65535));
    run_phase(3, 4, 1, 25, $urandom_range(0, 65535));
    run_phase($urandom_range(0, 255), $urandom_range(1, 1023), $urandom_range(0, 255),
              25, $urandom_range(0, 65535));

    $display("checked %0d results: %0d confirmed hits, %0d tentative hits, %0d new,",
             n_checked, n_outcome[0], n_outcome[1], n_outcome[2]);
    $display("%0d dropped on full table, %0d frame ends", n_outcome[3], n_outcome[4]);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
